@@ hw/rtl/crcfc_pkg.sv @@
// package with types, constants and the crc byte update of the frame checker
package crcfc_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [8:0]  MIN_BURST   = 9'd5;
  localparam logic [7:0]  COUNT_SAT   = 8'd255;
  localparam logic [7:0]  MAX_LEN     = 8'(MAX_PAYLOAD);

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_CRC_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       item_kind;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    status_t     frame_status;
    logic [7:0]  frame_address;
    logic [7:0]  frame_command;
    logic [7:0]  frame_length;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
    logic        run_last;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/crcfc_in_if.sv @@
// input channel of the frame checker: one received byte per item
interface crcfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       burst_end;

  modport source (output valid, output rx_byte, output burst_end, input ready);
  modport sink (input valid, input rx_byte, input burst_end, output ready);
endinterface

@@ hw/rtl/crcfc_out_if.sv @@
// output channel of the frame checker: payload byte or frame status per item
interface crcfc_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_index;
  logic [1:0]  frame_status;
  logic [7:0]  frame_address;
  logic [7:0]  frame_command;
  logic [7:0]  frame_length;
  logic [15:0] crc_received;
  logic [15:0] crc_computed;
  logic        run_last;

  modport source (
    output valid, output item_kind, output payload_byte, output payload_index,
    output frame_status, output frame_address, output frame_command,
    output frame_length, output crc_received, output crc_computed, output run_last,
    input ready
  );
  modport sink (
    input valid, input item_kind, input payload_byte, input payload_index,
    input frame_status, input frame_address, input frame_command,
    input frame_length, input crc_received, input crc_computed, input run_last,
    output ready
  );
endinterface

@@ hw/rtl/crc16_frame_checker.sv @@
// top level of the crc16 frame checker: framing, crc check and result queue
// usage:
//   in_ch carries one received byte per item, burst_end set on the last
//   byte of a burst. out_ch carries a payload item for each payload byte
//   (tagged with its index; none if the length exceeds MAX_LEN) and one
//   status item at the end of each burst with the header fields, both
//   crcs and the verdict. the consumer keeps the payload only when the
//   status is ok. an input byte is folded into the frame state in the
//   cycle it is accepted, and its results are registered in the queue.
//   throughput is one byte per cycle while in_ch.ready is high; the crc byte
//   update is combinational. a final payload byte yields two items, which
//   leave the three-entry result queue at one item per cycle unless stalled.
//   in_ch.ready is high while the queue holds at most one item, so input
//   keeps flowing while a result waits; when the receiver stalls the
//   queue fills and in_ch.ready drops until items are taken.
//   synchronous reset clears the frame state and empties the queue; the
//   block is ready in the cycle after reset is released.
module crc16_frame_checker (
  input  logic               clk,
  input  logic               rst,
  crcfc_in_if.sink           in_ch,
  crcfc_out_if.source        out_ch
);
  import crcfc_pkg::*;

  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  address_reg, address_reg_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [15:0] crc_taken, crc_taken_next;

  result_t     q [3];
  result_t     q_next [3];
  logic [1:0]  q_count, q_count_next;

  logic        in_acc;
  logic        pop;
  logic        active;
  logic [8:0]  p9;
  logic [8:0]  n9;
  logic [8:0]  len_p3;
  logic [8:0]  len_p4;
  logic [8:0]  len_p5;
  logic        emit_payload;
  status_t     status;
  result_t     payload_res;
  result_t     status_res;
  result_t     res0, res1;
  logic [1:0]  n_res;
  logic [1:0]  base;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !q_count[1];
  assign out_ch.valid = (q_count != 2'd0);
  assign pop          = out_ch.valid && out_ch.ready;

  // frame state update
  always_comb begin
    active           = (byte_count != COUNT_SAT);
    address_reg_next = address_reg;
    command_reg_next = command_reg;
    length_reg_next  = length_reg;
    crc_accum_next   = crc_accum;
    crc_taken_next   = crc_taken;
    byte_count_next  = byte_count;
    p9               = {1'b0, byte_count};
    if (active && byte_count == 8'd0) begin
      address_reg_next = in_ch.rx_byte;
    end
    if (active && byte_count == 8'd1) begin
      command_reg_next = in_ch.rx_byte;
    end
    if (active && byte_count == 8'd2) begin
      length_reg_next = in_ch.rx_byte;
    end
    len_p3 = {1'b0, length_reg_next} + 9'd3;
    len_p4 = {1'b0, length_reg_next} + 9'd4;
    len_p5 = {1'b0, length_reg_next} + 9'd5;
    if (active && p9 < len_p3) begin
      crc_accum_next = crc_update(crc_accum, in_ch.rx_byte);
    end
    if (active && p9 == len_p3) begin
      crc_taken_next = {crc_taken[15:8], in_ch.rx_byte};
    end else if (active && p9 == len_p4) begin
      crc_taken_next = {in_ch.rx_byte, crc_taken[7:0]};
    end
    if (active) begin
      byte_count_next = byte_count + 8'd1;
    end
    emit_payload = active && (byte_count >= 8'd3) && (p9 < len_p3)
                   && (length_reg_next <= MAX_LEN);
    n9 = p9 + 9'd1;
    if (n9 < MIN_BURST) begin
      status = ST_SHORT;
    end else if (length_reg_next > MAX_LEN) begin
      status = ST_TOO_LARGE;
    end else if (n9 < len_p5) begin
      status = ST_SHORT;
    end else if (crc_taken_next != crc_accum_next) begin
      status = ST_CRC_BAD;
    end else begin
      status = ST_OK;
    end
  end

  // result items
  always_comb begin
    payload_res               = '0;
    payload_res.item_kind     = KIND_PAYLOAD;
    payload_res.payload_byte  = in_ch.rx_byte;
    payload_res.payload_index = 6'(byte_count - 8'd3);
    payload_res.run_last      = !in_ch.burst_end;

    status_res                = '0;
    status_res.item_kind      = KIND_STATUS;
    status_res.frame_status   = status;
    status_res.frame_address  = address_reg_next;
    status_res.frame_command  = command_reg_next;
    status_res.frame_length   = length_reg_next;
    status_res.crc_received   = crc_taken_next;
    status_res.crc_computed   = crc_accum_next;
    status_res.run_last       = 1'b1;

    res0  = emit_payload ? payload_res : status_res;
    res1  = status_res;
    n_res = 2'd0;
    if (in_acc) begin
      n_res = 2'({1'b0, emit_payload} + {1'b0, in_ch.burst_end});
    end
  end

  // result queue, head at entry zero
  always_comb begin
    q_next = q;
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
    end
    base = q_count - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      if (n_res != 2'd0 && base == 2'(i)) begin
        q_next[i] = res0;
      end
      if (n_res == 2'd2 && 2'(base + 2'd1) == 2'(i)) begin
        q_next[i] = res1;
      end
    end
    q_count_next = base + n_res;
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      q_count     <= 2'd0;
      byte_count  <= 8'd0;
      address_reg <= 8'd0;
      command_reg <= 8'd0;
      length_reg  <= 8'd0;
      crc_accum   <= CRC_INIT;
      crc_taken   <= 16'd0;
    end else begin
      q_count <= q_count_next;
      if (in_acc && in_ch.burst_end) begin
        byte_count  <= 8'd0;
        address_reg <= 8'd0;
        command_reg <= 8'd0;
        length_reg  <= 8'd0;
        crc_accum   <= CRC_INIT;
        crc_taken   <= 16'd0;
      end else if (in_acc) begin
        byte_count  <= byte_count_next;
        address_reg <= address_reg_next;
        command_reg <= command_reg_next;
        length_reg  <= length_reg_next;
        crc_accum   <= crc_accum_next;
        crc_taken   <= crc_taken_next;
      end
    end
  end

  assign out_ch.item_kind     = q[0].item_kind;
  assign out_ch.payload_byte  = q[0].payload_byte;
  assign out_ch.payload_index = q[0].payload_index;
  assign out_ch.frame_status  = q[0].frame_status;
  assign out_ch.frame_address = q[0].frame_address;
  assign out_ch.frame_command = q[0].frame_command;
  assign out_ch.frame_length  = q[0].frame_length;
  assign out_ch.crc_received  = q[0].crc_received;
  assign out_ch.crc_computed  = q[0].crc_computed;
  assign out_ch.run_last      = q[0].run_last;

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> q_count <= 2'd1)
    else $error("result queue overflow");

  // a burst end restarts framing
  a_burst_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.burst_end |=> byte_count == 8'd0 && crc_accum == CRC_INIT)
    else $error("frame state not cleared after burst end");

  // byte count advances by one until it saturates
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !in_ch.burst_end && byte_count != COUNT_SAT
    |=> byte_count == 8'($past(byte_count) + 8'd1))
    else $error("byte count did not advance");

  // a status item always closes its input's results
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.item_kind == KIND_STATUS |-> out_ch.run_last)
    else $error("status item without run_last");

endmodule
